/* src/tccs_pkg.sv */
`timescale 1ns / 1ps

package tccs_pkg;

  // Default screen geometry
  localparam int DEF_SCREEN_COLUMNS = 80;
  localparam int DEF_SCREEN_ROWS    = 25;
  localparam int DEF_TAB_STEP       = 4;

  // Field widths on the stream ports
  localparam int CODE_W      = 8;
  localparam int ATTR_W      = 8;
  localparam int PORT_ROW_W  = 5;
  localparam int PORT_COL_W  = 7;
  localparam int CELL_W      = 16;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  // Attribute after reset, and the attribute of the cells cleared at reset
  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;

  // Control characters
  localparam logic [CODE_W-1:0] CODE_NEWLINE = 8'd10;
  localparam logic [CODE_W-1:0] CODE_RETURN  = 8'd13;
  localparam logic [CODE_W-1:0] CODE_TAB     = 8'd9;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;

  // Decoded operation of one input beat
  typedef enum logic [2:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_RETURN,
    OP_TAB,
    OP_READ,
    OP_READ_NONE
  } op_e;

  // Queue entry: decoded command plus the attribute in force at accept time
  typedef struct packed {
    op_e                   op;
    logic [ATTR_W-1:0]     attr;
    logic [CODE_W-1:0]     code;
    logic [PORT_ROW_W-1:0] row;
    logic [PORT_COL_W-1:0] col;
  } cmd_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_BLANK
  } st_e;

endpackage

/* src/tccs_front.sv */
`timescale 1ns / 1ps

module tccs_front #(
  parameter int SCREEN_COLUMNS = tccs_pkg::DEF_SCREEN_COLUMNS,
  parameter int SCREEN_ROWS    = tccs_pkg::DEF_SCREEN_ROWS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // attribute register write
  input  logic                                cfg_we_i,
  input  logic [tccs_pkg::ATTR_W-1:0]         cfg_wdata_i,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [tccs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  logic                                s_axis_tuser,
  // back end still clearing the screen store
  input  logic                                init_busy_i,
  // push side of the command queue
  output logic                                push_valid_o,
  input  logic                                push_ready_i,
  output tccs_pkg::cmd_t                      push_data_o
);

  logic [tccs_pkg::ATTR_W-1:0]     attr_q;
  logic [tccs_pkg::CODE_W-1:0]     code;
  logic [tccs_pkg::PORT_ROW_W-1:0] rrow;
  logic [tccs_pkg::PORT_COL_W-1:0] rcol;
  logic                            in_range;
  tccs_pkg::op_e                   op;

  // attribute register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= tccs_pkg::RESET_ATTR;
    end else if (cfg_we_i) begin
      attr_q <= cfg_wdata_i;
    end
  end

  // unpack beat
  assign code = s_axis_tdata[7:0];
  assign rrow = s_axis_tdata[12:8];
  assign rcol = s_axis_tdata[19:13];

  assign in_range = (32'(rrow) < SCREEN_ROWS) && (32'(rcol) < SCREEN_COLUMNS);

  // classify the beat
  always_comb begin
    op = tccs_pkg::OP_PUT;
    if (s_axis_tuser) begin
      op = in_range ? tccs_pkg::OP_READ : tccs_pkg::OP_READ_NONE;
    end else begin
      case (code)
        tccs_pkg::CODE_NEWLINE: op = tccs_pkg::OP_NEWLINE;
        tccs_pkg::CODE_RETURN:  op = tccs_pkg::OP_RETURN;
        tccs_pkg::CODE_TAB:     op = tccs_pkg::OP_TAB;
        default:                op = tccs_pkg::OP_PUT;
      endcase
    end
  end

  // no beats taken while the store is cleared after reset
  assign s_axis_tready = push_ready_i && !init_busy_i;
  assign push_valid_o  = s_axis_tvalid && !init_busy_i;

  always_comb begin
    push_data_o.op   = op;
    push_data_o.attr = attr_q;
    push_data_o.code = code;
    push_data_o.row  = rrow;
    push_data_o.col  = rcol;
  end

endmodule

/* src/tccs_fifo.sv */
`timescale 1ns / 1ps

module tccs_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  tccs_pkg::cmd_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output tccs_pkg::cmd_t pop_data_o
);

  tccs_pkg::cmd_t                     entry_q [tccs_pkg::QUEUE_DEPTH];
  logic [tccs_pkg::QUEUE_PTR_W-1:0]   wr_ptr_q;
  logic [tccs_pkg::QUEUE_PTR_W-1:0]   rd_ptr_q;
  logic [tccs_pkg::QUEUE_PTR_W:0]     count_q;
  logic                               push;
  logic                               pop;

  assign push_ready_o = (count_q != (tccs_pkg::QUEUE_PTR_W + 1)'(tccs_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = entry_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* src/tccs_back.sv */
`timescale 1ns / 1ps

module tccs_back #(
  parameter int SCREEN_COLUMNS = tccs_pkg::DEF_SCREEN_COLUMNS,
  parameter int SCREEN_ROWS    = tccs_pkg::DEF_SCREEN_ROWS,
  parameter int TAB_STEP       = tccs_pkg::DEF_TAB_STEP
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // pop side of the command queue
  input  logic                               cmd_valid_i,
  output logic                               cmd_ready_o,
  input  tccs_pkg::cmd_t                     cmd_i,
  // clear pass after reset in progress
  output logic                               init_busy_o,
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [tccs_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  localparam int CELLS  = SCREEN_ROWS * SCREEN_COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int ROW_W  = $clog2(SCREEN_ROWS);
  localparam int ROW_SW = ROW_W + 1;
  localparam int COL_W  = $clog2(SCREEN_COLUMNS);
  localparam int SUM_W  = $clog2(SCREEN_COLUMNS + TAB_STEP);

  tccs_pkg::st_e state_q, state_d;

  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  top_q, top_d;
  logic [ADDR_W-1:0] cnt_q, cnt_d;
  logic [ADDR_W-1:0] base_q, base_d;
  logic [tccs_pkg::ATTR_W-1:0] battr_q, battr_d;

  logic                              out_valid_q, out_valid_d;
  logic [tccs_pkg::PORT_ROW_W-1:0]   out_row_q, out_row_d;
  logic [tccs_pkg::PORT_COL_W-1:0]   out_col_q, out_col_d;
  logic [tccs_pkg::CELL_W-1:0]       out_cell_q, out_cell_d;
  logic                              out_scr_q, out_scr_d;

  logic [tccs_pkg::CELL_W-1:0] screen_mem [CELLS];
  logic [tccs_pkg::CELL_W-1:0] rd_data_q;
  logic                        mem_we;
  logic [ADDR_W-1:0]           mem_waddr;
  logic [tccs_pkg::CELL_W-1:0] mem_wdata;
  logic                        rd_en;
  logic [ADDR_W-1:0]           rd_addr;

  logic              slot_free;
  logic              pop;
  logic [SUM_W-1:0]  col_sum;
  logic              wrap;
  logic              adv_row;
  logic              last_row;
  logic              scroll;
  logic              sweep_last;
  logic              blank_last;
  logic [ROW_SW-1:0] cur_sum;
  logic [ROW_SW-1:0] rd_sum;
  logic [ROW_W-1:0]  cur_phys;
  logic [ROW_W-1:0]  rd_phys;
  logic [ROW_W-1:0]  top_next;

  // handshake with queue and output slot
  assign slot_free   = !out_valid_q || m_axis_tready;
  assign pop         = (state_q == tccs_pkg::ST_IDLE) && cmd_valid_i && slot_free;
  assign cmd_ready_o = pop;
  assign init_busy_o = (state_q == tccs_pkg::ST_INIT);

  // cursor advance for put and tab
  assign col_sum  = SUM_W'(col_q) +
                    ((cmd_i.op == tccs_pkg::OP_TAB) ? SUM_W'(TAB_STEP) : SUM_W'(1));
  assign wrap     = (col_sum >= SUM_W'(SCREEN_COLUMNS));
  assign adv_row  = (cmd_i.op == tccs_pkg::OP_NEWLINE) ||
                    (((cmd_i.op == tccs_pkg::OP_TAB) || (cmd_i.op == tccs_pkg::OP_PUT)) && wrap);
  assign last_row = (row_q == ROW_W'(SCREEN_ROWS - 1));
  assign scroll   = adv_row && last_row;

  assign sweep_last = (cnt_q == ADDR_W'(CELLS - 1));
  assign blank_last = (cnt_q == ADDR_W'(SCREEN_COLUMNS - 1));

  // rows sit in the store as a ring starting at top_q
  assign cur_sum  = ROW_SW'(row_q) + ROW_SW'(top_q);
  assign cur_phys = (cur_sum >= ROW_SW'(SCREEN_ROWS)) ?
                    ROW_W'(cur_sum - ROW_SW'(SCREEN_ROWS)) : ROW_W'(cur_sum);
  assign rd_sum   = ROW_SW'(ROW_W'(cmd_i.row)) + ROW_SW'(top_q);
  assign rd_phys  = (rd_sum >= ROW_SW'(SCREEN_ROWS)) ?
                    ROW_W'(rd_sum - ROW_SW'(SCREEN_ROWS)) : ROW_W'(rd_sum);
  assign top_next = (top_q == ROW_W'(SCREEN_ROWS - 1)) ? '0 : top_q + 1'b1;

  assign rd_addr = ADDR_W'(rd_phys * SCREEN_COLUMNS) + ADDR_W'(COL_W'(cmd_i.col));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tccs_pkg::ST_INIT: begin
        if (sweep_last) begin
          state_d = tccs_pkg::ST_IDLE;
        end
      end
      tccs_pkg::ST_IDLE: begin
        if (pop) begin
          if (cmd_i.op == tccs_pkg::OP_READ) begin
            state_d = tccs_pkg::ST_READ;
          end else if (scroll) begin
            state_d = tccs_pkg::ST_BLANK;
          end
        end
      end
      tccs_pkg::ST_READ: begin
        state_d = tccs_pkg::ST_IDLE;
      end
      tccs_pkg::ST_BLANK: begin
        if (blank_last) begin
          state_d = tccs_pkg::ST_IDLE;
        end
      end
      default: state_d = tccs_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs per state
  always_comb begin
    row_d       = row_q;
    col_d       = col_q;
    top_d       = top_q;
    cnt_d       = cnt_q;
    base_d      = base_q;
    battr_d     = battr_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    rd_en       = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    out_cell_d  = out_cell_q;
    out_scr_d   = out_scr_q;
    case (state_q)
      tccs_pkg::ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q;
        mem_wdata = {tccs_pkg::RESET_ATTR, 8'h00};
        cnt_d     = sweep_last ? '0 : cnt_q + 1'b1;
      end
      tccs_pkg::ST_IDLE: begin
        if (pop) begin
          case (cmd_i.op)
            tccs_pkg::OP_READ: begin
              rd_en = 1'b1;
            end
            tccs_pkg::OP_READ_NONE: begin
              out_valid_d = 1'b1;
            end
            tccs_pkg::OP_RETURN: begin
              col_d       = '0;
              out_valid_d = 1'b1;
            end
            tccs_pkg::OP_NEWLINE, tccs_pkg::OP_TAB, tccs_pkg::OP_PUT: begin
              if (cmd_i.op == tccs_pkg::OP_PUT) begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(cur_phys * SCREEN_COLUMNS) + ADDR_W'(col_q);
                mem_wdata = {cmd_i.attr, cmd_i.code};
              end
              if (adv_row) begin
                col_d = '0;
                if (last_row) begin
                  // old top row becomes the new bottom row, blanked next
                  top_d   = top_next;
                  base_d  = ADDR_W'(top_q * SCREEN_COLUMNS);
                  battr_d = cmd_i.attr;
                  cnt_d   = '0;
                end else begin
                  row_d = row_q + 1'b1;
                end
              end else begin
                col_d = COL_W'(col_sum);
              end
              out_valid_d = 1'b1;
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
          out_row_d  = tccs_pkg::PORT_ROW_W'(row_d);
          out_col_d  = tccs_pkg::PORT_COL_W'(col_d);
          out_cell_d = '0;
          out_scr_d  = scroll && (cmd_i.op != tccs_pkg::OP_READ) &&
                       (cmd_i.op != tccs_pkg::OP_READ_NONE);
        end
      end
      tccs_pkg::ST_READ: begin
        out_valid_d = 1'b1;
        out_cell_d  = rd_data_q;
      end
      tccs_pkg::ST_BLANK: begin
        mem_we    = 1'b1;
        mem_waddr = base_q + cnt_q;
        mem_wdata = {battr_q, 8'h00};
        cnt_d     = blank_last ? '0 : cnt_q + 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tccs_pkg::ST_INIT;
      row_q       <= '0;
      col_q       <= '0;
      top_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      top_q       <= top_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    base_q     <= base_d;
    battr_q    <= battr_d;
    out_row_q  <= out_row_d;
    out_col_q  <= out_col_d;
    out_cell_q <= out_cell_d;
    out_scr_q  <= out_scr_d;
  end

  // screen store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      screen_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_q <= screen_mem[rd_addr];
    end
  end

  // result beat
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_scr_q, out_cell_q, out_col_q, out_row_q};

  // cursor stays on screen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(col_q) < SCREEN_COLUMNS) && (32'(row_q) < SCREEN_ROWS))
    else $error("cursor off screen");

  // ring offset stays within the row count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(top_q) < SCREEN_ROWS)
    else $error("top row offset out of range");

  // a command is only taken when the result slot can hold its result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (!out_valid_q || m_axis_tready))
    else $error("command popped with result slot busy");

  // a scrolling put, newline or tab goes on to blank the new bottom row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && scroll && (cmd_i.op != tccs_pkg::OP_READ) &&
     (cmd_i.op != tccs_pkg::OP_READ_NONE)) |=> (state_q == tccs_pkg::ST_BLANK))
    else $error("scroll without blanking pass");

  // a read result follows its pop, through the registered read port and the read state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && (cmd_i.op == tccs_pkg::OP_READ)) |=> ##1 out_valid_q)
    else $error("read result missing");

endmodule

/* src/text_console_cursor_scroll.sv */
`timescale 1ns / 1ps

// Text console with a cursor and a SCREEN_ROWS x SCREEN_COLUMNS store of 16-bit cells
// (attribute high byte, character low byte). Beats enter a two-entry command queue
// after decoding; a back-end sequencer owns the cursor and the store. The store keeps
// its rows as a ring behind a top-row offset, so a scroll only advances the offset and
// rewrites the new bottom row: a scrolling put, newline or tab then blanks that row's
// SCREEN_COLUMNS cells (80 by default) on the single write port, while its result beat
// goes out at once. While the result stream does not stall, the rate is one beat a
// cycle for a put, newline, tab, return or out-of-range read that does not scroll; an
// in-range read holds off the next beat while it passes the registered read port of the
// store. A result beat is registered after the command queue, an in-range read after
// the read port as well. After reset the store is cleared to attribute 0x0F blanks,
// one cell a cycle, over all SCREEN_ROWS*SCREEN_COLUMNS cells (2000 by default); no
// input beat is taken during that pass, though the attribute register can be written.
module text_console_cursor_scroll #(
  parameter int SCREEN_COLUMNS = tccs_pkg::DEF_SCREEN_COLUMNS,
  parameter int SCREEN_ROWS    = tccs_pkg::DEF_SCREEN_ROWS,
  parameter int TAB_STEP       = tccs_pkg::DEF_TAB_STEP
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // text_attribute register
  input  logic                               cfg_we_i,
  input  logic [tccs_pkg::ATTR_W-1:0]        cfg_wdata_i,
  // input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [7:0] char_code, [12:8] read_row, [19:13] read_col, [23:20] zero
  input  logic [tccs_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // [0] action: 0 put, 1 read
  input  logic                               s_axis_tuser,
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [4:0] cursor_row, [11:5] cursor_col, [27:12] cell_value, [28] scrolled, [31:29] zero
  output logic [tccs_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  logic           init_busy;
  logic           push_valid;
  logic           push_ready;
  tccs_pkg::cmd_t push_data;
  logic           cmd_valid;
  logic           cmd_ready;
  tccs_pkg::cmd_t cmd;

  tccs_front #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .init_busy_i   (init_busy),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_data_o   (push_data)
  );

  tccs_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (cmd_valid),
    .pop_ready_i  (cmd_ready),
    .pop_data_o   (cmd)
  );

  tccs_back #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS),
    .TAB_STEP       (TAB_STEP)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_ready_o   (cmd_ready),
    .cmd_i         (cmd),
    .init_busy_o   (init_busy),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
